FILE: rtl/core/ffe_pkg.sv
// ----------------------------------------------------------------------------
// ffe_pkg
// Shared sizes, register indexes and item codes of the frame flip engine.
// ----------------------------------------------------------------------------
package ffe_pkg;

  // Frame store geometry
  localparam int unsigned MAX_WIDTH   = 64;
  localparam int unsigned MAX_HEIGHT  = 64;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_W = $clog2(STORE_DEPTH + 1);

  // Payload widths
  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned DIM_W   = 7;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_HORIZONTAL = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 7'd64;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Stage metadata that travels alongside the store read
  typedef struct packed {
    logic valid;
    logic last;
    logic valid_res;
  } ffe_meta_t;

endpackage

FILE: rtl/core/ffe_in_if.sv
// ----------------------------------------------------------------------------
// ffe_in_if
// Input channel: one beat is a pixel load or a read-out request.
// ----------------------------------------------------------------------------
interface ffe_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [ffe_pkg::PIXEL_W-1:0] pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

FILE: rtl/core/ffe_out_if.sv
// ----------------------------------------------------------------------------
// ffe_out_if
// Result channel: one beat per read-out request.
// ----------------------------------------------------------------------------
interface ffe_out_if;
  logic                        valid;
  logic                        ready;
  logic [ffe_pkg::PIXEL_W-1:0] pixel_out;
  logic                        last;
  logic                        valid_res;

  modport source (output valid, output pixel_out, output last, output valid_res,
                  input ready);
  modport sink   (input valid, input pixel_out, input last, input valid_res,
                  output ready);
endinterface

FILE: rtl/core/ffe_ram.sv
// ----------------------------------------------------------------------------
// ffe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, holds its data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/frame_flip_engine_top.sv
// ----------------------------------------------------------------------------
// frame_flip_engine_top
// Mirrors a frame of 32-bit pixels left-right or top-bottom by addressing.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries load beats (mode 0, pixel in raster order) and read-out
//   beats (mode 1). Loads fill the frame store until width x height pixels
//   are held; each read-out then returns one result beat on res_o with the
//   pixel at the mirrored position, last set on the final pixel of the frame.
//   A read-out before the frame is complete returns valid_res 0 and pixel 0.
//   A load into a complete frame starts a new one.
//   Configuration (width, height, flip direction) is written through cfg_*
//   while the block is idle.
// Timing:
//   One beat per cycle on item_i while item_i.ready is high. A read-out is
//   registered first in the store read, then in the output register, and
//   shows on res_o from there; a stall on res_o can hold it in between.
//   Loads produce no result.
// Reset and stalls:
//   Reset clears the load count and read position and restores the register
//   defaults; the frame store is not cleared. When res_o stalls, a pending
//   result waits in the store-read stage and item_i.ready drops until the
//   output register drains.
// ----------------------------------------------------------------------------
module frame_flip_engine_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ffe_pkg::CFG_W-1:0]     cfg_data_i,
  ffe_in_if.sink                        item_i,
  ffe_out_if.source                     res_o
);

  localparam int unsigned COL_W   = ffe_pkg::COL_W;
  localparam int unsigned ROW_W   = ffe_pkg::ROW_W;
  localparam int unsigned ADDR_W  = ffe_pkg::ADDR_W;
  localparam int unsigned COUNT_W = ffe_pkg::COUNT_W;
  localparam int unsigned DIM_W   = ffe_pkg::DIM_W;
  localparam int unsigned PIXEL_W = ffe_pkg::PIXEL_W;
  localparam int unsigned PROD_W  = 2 * DIM_W;
  localparam logic [DIM_W-1:0] MaxW = DIM_W'(ffe_pkg::MAX_WIDTH);
  localparam logic [DIM_W-1:0] MaxH = DIM_W'(ffe_pkg::MAX_HEIGHT);

  // Configuration registers
  logic [DIM_W-1:0] frame_width_q;
  logic [DIM_W-1:0] frame_height_q;
  logic             flip_horizontal_q;

  // Frame state
  logic [COUNT_W-1:0] load_count_q, load_count_d;
  logic [COL_W-1:0]   read_col_q, read_col_d;
  logic [ROW_W-1:0]   read_row_q, read_row_d;

  // Pipeline
  ffe_pkg::ffe_meta_t s1_q, s1_d;
  logic               out_valid_q;
  logic [PIXEL_W-1:0] out_pixel_q;
  logic               out_last_q;
  logic               out_vres_q;

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [PROD_W-1:0]  total;
  logic               complete;
  logic               accept, is_load, is_read;
  logic               s1_adv;
  logic [COL_W-1:0]   col_eff, col_src;
  logic [ROW_W-1:0]   row_eff, row_src;
  logic [PROD_W-1:0]  src;
  logic               is_last;
  logic [COUNT_W-1:0] load_base;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [PIXEL_W-1:0] ram_rdata;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q     <= ffe_pkg::FRAME_WIDTH_RST;
      frame_height_q    <= ffe_pkg::FRAME_HEIGHT_RST;
      flip_horizontal_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffe_pkg::REG_FRAME_WIDTH:     frame_width_q     <= cfg_data_i[DIM_W-1:0];
        ffe_pkg::REG_FRAME_HEIGHT:    frame_height_q    <= cfg_data_i[DIM_W-1:0];
        ffe_pkg::REG_FLIP_HORIZONTAL: flip_horizontal_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (frame_width_q > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (frame_height_q > MaxH) begin
      h_eff = MaxH;
    end else begin
      h_eff = frame_height_q;
    end
  end

  assign total    = w_eff * h_eff;
  assign complete = PROD_W'(load_count_q) >= total;

  // Handshake
  assign s1_adv       = s1_q.valid && (!out_valid_q || res_o.ready);
  assign item_i.ready = !s1_q.valid || s1_adv;
  assign accept       = item_i.valid && item_i.ready;
  assign is_load      = accept && (item_i.mode == ffe_pkg::MODE_LOAD);
  assign is_read      = accept && (item_i.mode == ffe_pkg::MODE_READ);

  // Read position, restarted per coordinate when outside the frame
  assign col_eff = (DIM_W'(read_col_q) >= w_eff) ? '0 : read_col_q;
  assign row_eff = (DIM_W'(read_row_q) >= h_eff) ? '0 : read_row_q;
  assign is_last = (DIM_W'(row_eff) == h_eff - DIM_W'(1))
                && (DIM_W'(col_eff) == w_eff - DIM_W'(1));

  // Mirrored source address: one row multiply plus a column offset
  assign col_src = flip_horizontal_q ? COL_W'(w_eff - DIM_W'(1) - DIM_W'(col_eff))
                                     : col_eff;
  assign row_src = flip_horizontal_q ? row_eff
                                     : ROW_W'(h_eff - DIM_W'(1) - DIM_W'(row_eff));
  assign src     = PROD_W'(row_src) * PROD_W'(w_eff) + PROD_W'(col_src);

  // Load address: a load into a complete frame starts over
  assign load_base = complete ? '0 : load_count_q;

  assign ram_we    = is_load;
  assign ram_waddr = load_base[ADDR_W-1:0];
  assign ram_re    = is_read && complete;
  assign ram_raddr = src[ADDR_W-1:0];

  // Frame state update
  always_comb begin
    load_count_d = load_count_q;
    read_col_d   = read_col_q;
    read_row_d   = read_row_q;
    if (is_load) begin
      load_count_d = load_base + COUNT_W'(1);
      if (complete) begin
        read_col_d = '0;
        read_row_d = '0;
      end
    end else if (is_read && complete) begin
      if (is_last) begin
        load_count_d = '0;
        read_col_d   = '0;
        read_row_d   = '0;
      end else if (DIM_W'(col_eff) + DIM_W'(1) >= w_eff) begin
        read_col_d = '0;
        read_row_d = row_eff + ROW_W'(1);
      end else begin
        read_col_d = col_eff + COL_W'(1);
        read_row_d = row_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      read_col_q   <= '0;
      read_row_q   <= '0;
    end else begin
      load_count_q <= load_count_d;
      read_col_q   <= read_col_d;
      read_row_q   <= read_row_d;
    end
  end

  // Store-read stage metadata
  always_comb begin
    s1_d = s1_q;
    if (is_read) begin
      s1_d.valid     = 1'b1;
      s1_d.last      = complete && is_last;
      s1_d.valid_res = complete;
    end else if (s1_adv) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  // Frame store
  ffe_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (ffe_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_i.pixel_in),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pixel_q <= s1_q.valid_res ? ram_rdata : '0;
      out_last_q  <= s1_q.last;
      out_vres_q  <= s1_q.valid_res;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.pixel_out = out_pixel_q;
  assign res_o.last      = out_last_q;
  assign res_o.valid_res = out_vres_q;

endmodule

FILE: verif/tb_frame_flip_engine_top.sv
// ----------------------------------------------------------------------------
// tb_frame_flip_engine_top
// Self-checking bench for the frame flip engine. A directed table covers reset,
// the 1x1 frame, out-of-range sizes, early read-outs, loads into a complete
// frame and size changes in mid-frame. Random frames with random geometry and
// content follow, under several idle and stall patterns. Every result beat is
// checked against a mirrored-addressing predictor kept in step with each
// accepted beat, or, for checked table rows, against the row's values.
// ----------------------------------------------------------------------------
module tb_frame_flip_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY         = 2;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_BEATS     = 80;
  localparam int MAX_REPORTS     = 10;

  localparam int unsigned PIXEL_W     = ffe_pkg::PIXEL_W;
  localparam int unsigned DIM_W       = ffe_pkg::DIM_W;
  localparam int unsigned CFG_W       = ffe_pkg::CFG_W;
  localparam int unsigned STORE_DEPTH = ffe_pkg::STORE_DEPTH;

  // Idle percentages per random phase: sender, receiver
  localparam int SEND_IDLE [4] = '{0, 76, 0, 22};
  localparam int RECV_IDLE [4] = '{0, 0, 76, 22};

  // One expected result beat
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last;
    logic               ok;
  } flip_res_t;

  // Directed table rows
  typedef enum logic [1:0] {ROW_LOAD, ROW_READ, ROW_CHECKED, ROW_GEOM} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [PIXEL_W-1:0] value;  // load pixel, or expected pixel of a checked read
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic               flip;
    logic               last;   // expected flags of a checked read
    logic               ok;
  } dir_row_t;

  localparam dir_row_t DIRECTED [31] = '{
    // read-out right after reset: frame not complete
    '{ROW_CHECKED, 32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    // zero sizes act as a 1x1 frame
    '{ROW_GEOM,    32'h0000_0000, 7'd0,   7'd0,   1'b1, 1'b0, 1'b0},
    '{ROW_LOAD,    32'hFFFF_FFFF, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_CHECKED, 32'hFFFF_FFFF, 7'd0,   7'd0,   1'b0, 1'b1, 1'b1},
    '{ROW_CHECKED, 32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    // 2x2 left-right, early read-out inside the loads
    '{ROW_GEOM,    32'h0000_0000, 7'd2,   7'd2,   1'b1, 1'b0, 1'b0},
    '{ROW_LOAD,    32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_LOAD,    32'h1111_1111, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_LOAD,    32'h2222_2222, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_CHECKED, 32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_LOAD,    32'h3333_3333, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_READ,    32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_READ,    32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    // load into a complete frame restarts it
    '{ROW_LOAD,    32'hA5A5_A5A5, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_LOAD,    32'h5A5A_5A5A, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_LOAD,    32'h0F0F_0F0F, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_LOAD,    32'hF0F0_F0F0, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    // same frame read top-bottom
    '{ROW_GEOM,    32'h0000_0000, 7'd2,   7'd2,   1'b0, 1'b0, 1'b0},
    '{ROW_READ,    32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_READ,    32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_READ,    32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_READ,    32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    // oversized registers act as 64x64; frame was released
    '{ROW_GEOM,    32'h0000_0000, 7'd127, 7'd127, 1'b1, 1'b0, 1'b0},
    '{ROW_CHECKED, 32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    // frame shrunk in mid-load becomes complete
    '{ROW_GEOM,    32'h0000_0000, 7'd2,   7'd2,   1'b1, 1'b0, 1'b0},
    '{ROW_LOAD,    32'h1234_5678, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_LOAD,    32'h9ABC_DEF0, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_GEOM,    32'h0000_0000, 7'd1,   7'd2,   1'b1, 1'b0, 1'b0},
    '{ROW_READ,    32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_READ,    32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_CHECKED, 32'h0000_0000, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ffe_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]              cfg_data_i;

  ffe_in_if  item_if ();
  ffe_out_if res_if ();

  frame_flip_engine_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .res_o      (res_if)
  );

  // Predictor state: register copies, frame store, counters
  logic [DIM_W-1:0]   geom_w    = ffe_pkg::FRAME_WIDTH_RST;
  logic [DIM_W-1:0]   geom_h    = ffe_pkg::FRAME_HEIGHT_RST;
  logic               geom_flip = 1'b1;
  logic [PIXEL_W-1:0] frame_mem [STORE_DEPTH];
  int                 loaded    = 0;
  int                 out_col   = 0;
  int                 out_row   = 0;

  flip_res_t mirrored_q [$];
  int        errors        = 0;
  int        beats_sent    = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  logic      hold_res      = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int clamp_dim(input int unsigned v, input int unsigned max_v);
    int r;
    r = v;
    if (v == 0) r = 1;
    else if (v > max_v) r = max_v;
    return r;
  endfunction

  function automatic int frame_pixels();
    return clamp_dim(geom_w, ffe_pkg::MAX_WIDTH) * clamp_dim(geom_h, ffe_pkg::MAX_HEIGHT);
  endfunction

  // Mirrored-addressing predictor: returns 1 when the beat yields a result
  function automatic bit mirror_step(input logic mode, input logic [PIXEL_W-1:0] pix,
                                     output flip_res_t res);
    int w, h, src;
    bit complete, at_end, has_res;
    w        = clamp_dim(geom_w, ffe_pkg::MAX_WIDTH);
    h        = clamp_dim(geom_h, ffe_pkg::MAX_HEIGHT);
    complete = (loaded >= w * h);
    res      = '0;
    has_res  = 1'b0;
    if (mode == ffe_pkg::MODE_LOAD) begin
      if (complete) begin
        loaded  = 0;
        out_col = 0;
        out_row = 0;
      end
      if (loaded < STORE_DEPTH) frame_mem[loaded] = pix;
      loaded++;
    end else begin
      has_res = 1'b1;
      if (complete) begin
        if (out_col >= w) out_col = 0;
        if (out_row >= h) out_row = 0;
        if (geom_flip) src = out_row * w + (w - 1 - out_col);
        else src = (h - 1 - out_row) * w + out_col;
        at_end    = (out_row == h - 1) && (out_col == w - 1);
        res.pixel = frame_mem[src];
        res.last  = at_end;
        res.ok    = 1'b1;
        if (at_end) begin
          loaded  = 0;
          out_col = 0;
          out_row = 0;
        end else if (out_col + 1 >= w) begin
          out_col = 0;
          out_row++;
        end else begin
          out_col++;
        end
      end
    end
    return has_res;
  endfunction

  task automatic log_mismatch(input string what, input logic [PIXEL_W-1:0] want_v,
                              input logic [PIXEL_W-1:0] got_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want_v, got_v);
  endtask

  // Offer one beat, with random idle cycles ahead of it, until it is taken
  task automatic push_beat(input logic mode, input logic [PIXEL_W-1:0] pix,
                           output bit has_res, output flip_res_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid    <= 1'b1;
    item_if.mode     <= mode;
    item_if.pixel_in <= pix;
    do @(posedge clk_i); while (!item_if.ready);
    has_res = mirror_step(mode, pix, res);
    beats_sent++;
  endtask

  task automatic send(input logic mode, input logic [PIXEL_W-1:0] pix);
    bit        has_res;
    flip_res_t res;
    push_beat(mode, pix, has_res, res);
    if (has_res) mirrored_q.push_back(res);
  endtask

  // Drain results, then give trailing loads time to finish
  task automatic settle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (mirrored_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic flip);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ffe_pkg::REG_FRAME_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    geom_w = w;
    cfg_idx_i  <= ffe_pkg::REG_FRAME_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    geom_h = h;
    cfg_idx_i  <= ffe_pkg::REG_FLIP_HORIZONTAL;
    cfg_data_i <= CFG_W'(flip);
    @(posedge clk_i);
    geom_flip = flip;
    cfg_we_i <= 1'b0;
  endtask

  // Mostly small sizes; now and then zero or at or past the maximum
  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    else if (r < 16) return DIM_W'($urandom_range(64, 127));
    else if (r < 30) return DIM_W'($urandom_range(7, 16));
    else return DIM_W'($urandom_range(1, 6));
  endfunction

  task automatic random_geometry();
    logic [DIM_W-1:0] w, h;
    w = pick_dim();
    h = pick_dim();
    if (clamp_dim(w, ffe_pkg::MAX_WIDTH) * clamp_dim(h, ffe_pkg::MAX_HEIGHT) > 128)
      h = DIM_W'($urandom_range(2));
    set_geometry(w, h, 1'($urandom_range(1)));
  endtask

  // One frame: loads with a few early read-outs, then full or partial read-out
  task automatic random_frame();
    int total, n_ld, n_rd;
    total = frame_pixels();
    n_ld  = ($urandom_range(99) < 10) ? $urandom_range(total) : total;
    repeat (n_ld) begin
      if ($urandom_range(99) < 6) send(ffe_pkg::MODE_READ, $urandom);
      send(ffe_pkg::MODE_LOAD, $urandom);
    end
    n_rd = ($urandom_range(99) < 70) ? total : $urandom_range(1, total);
    repeat (n_rd) send(ffe_pkg::MODE_READ, $urandom);
    // size change in mid read-out
    if (n_rd < total && $urandom_range(99) < 50) begin
      random_geometry();
      repeat ($urandom_range(1, frame_pixels())) send(ffe_pkg::MODE_READ, $urandom);
    end
  endtask

  task automatic check_result();
    flip_res_t want;
    if (mirrored_q.size() == 0) begin
      log_mismatch("unexpected result beat", '0, res_if.pixel_out);
    end else begin
      want = mirrored_q.pop_front();
      if (res_if.pixel_out !== want.pixel)
        log_mismatch("pixel_out", want.pixel, res_if.pixel_out);
      if (res_if.last !== want.last)
        log_mismatch("last", PIXEL_W'(want.last), PIXEL_W'(res_if.last));
      if (res_if.valid_res !== want.ok)
        log_mismatch("valid_res", PIXEL_W'(want.ok), PIXEL_W'(res_if.valid_res));
    end
  endtask

  // Result side: check each beat, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) check_result();
    res_if.ready <= !hold_res && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: cycles in a row with no beat on either channel
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) stuck = 0;
      else stuck++;
    end
    $display("** frame_flip_engine_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    dir_row_t  row;
    flip_res_t want, dummy;
    bit        has_res;
    int        goal;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = ffe_pkg::REG_FRAME_WIDTH;
    cfg_data_i       = '0;
    item_if.valid    = 1'b0;
    item_if.mode     = ffe_pkg::MODE_LOAD;
    item_if.pixel_in = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      case (row.kind)
        ROW_GEOM: set_geometry(row.w, row.h, row.flip);
        ROW_LOAD: send(ffe_pkg::MODE_LOAD, row.value);
        ROW_READ: send(ffe_pkg::MODE_READ, $urandom);
        default: begin
          push_beat(ffe_pkg::MODE_READ, $urandom, has_res, dummy);
          want.pixel = row.value;
          want.last  = row.last;
          want.ok    = row.ok;
          mirrored_q.push_back(want);
        end
      endcase
    end

    // Random phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      stall_pct    <= RECV_IDLE[ph];
      if (ph == 0) begin
        // long receiver hold-off while beats keep coming
        fork
          begin
            hold_res <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
            hold_res <= 1'b0;
          end
        join_none
      end
      goal = beats_sent + PHASE_BEATS;
      while (beats_sent < goal) begin
        if ($urandom_range(99) < 35) random_geometry();
        random_frame();
      end
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("** frame_flip_engine_top: PASSED **");
    else $display("** frame_flip_engine_top: FAILED **");
    $finish;
  end

endmodule
